// ===== src/pcgr_pkg.sv =====
// Shared constants, types and functions of the bounded PCG32 generator.
package pcgr_pkg;

  // LCG constants
  localparam logic [63:0] PcgMul = 64'd6364136223846793005;
  localparam logic [63:0] PcgInc = 64'd1442695040888963407;
  localparam logic [31:0] PcgMulLo = PcgMul[31:0];
  localparam logic [31:0] PcgMulHi = PcgMul[63:32];

  // State after reset: reseed with zero, folded at elaboration
  localparam logic [63:0] PcgResetState = PcgInc * PcgMul + PcgInc;

  // XSH-RR shift amounts
  localparam int unsigned XshShift = 18;
  localparam int unsigned OutShift = 27;
  localparam int unsigned RotShift = 59;

  // Operation codes
  localparam logic OpReseed = 1'b0;
  localparam logic OpDraw   = 1'b1;

  // Classified command: reseed carries seed + increment,
  // draw carries {mask, bound}
  typedef struct packed {
    logic        op;
    logic [63:0] data;
  } pcgr_cmd_t;

  // Ones covering the highest set bit of (b | 1)
  function automatic logic [31:0] cover_mask(input logic [31:0] b);
    logic [31:0] m;
    m = b | 32'd1;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  // XSH-RR output of one LCG state
  function automatic logic [31:0] pcg_output(input logic [63:0] s);
    logic [63:0] xs;
    logic [31:0] x;
    logic [4:0]  rot;
    logic [63:0] dbl;
    xs  = ((s >> XshShift) ^ s) >> OutShift;
    x   = xs[31:0];
    rot = 5'(s >> RotShift);
    dbl = {x, x} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ===== src/pcgr_front.sv =====
// Front end: classifies an incoming beat into a reseed or draw command.
module pcgr_front import pcgr_pkg::*; (
  input  logic        operation_i,
  input  logic [63:0] seed_i,
  input  logic [31:0] bound_i,
  output pcgr_cmd_t   cmd_o
);

  // Reseed pre-adds the increment; draw precomputes its mask
  always_comb begin
    cmd_o.op = operation_i;
    if (operation_i == OpDraw) begin
      cmd_o.data = {cover_mask(bound_i), bound_i};
    end else begin
      cmd_o.data = seed_i + PcgInc;
    end
  end

endmodule

// ===== src/pcgr_cmd_fifo.sv =====
// Two-entry command queue between front and back end.
module pcgr_cmd_fifo import pcgr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pcgr_cmd_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output pcgr_cmd_t data_o,
  output logic      empty_o
);

  pcgr_cmd_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/pcgr_back.sv =====
// Back end: LCG state, shared 32x32 multiplier sequence, rejection loop, result register.
module pcgr_back import pcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pcgr_cmd_t   cmd_i,
  input  logic        cmd_empty_i,
  output logic        cmd_pop_o,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] value_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StTry  = 3'd1;
  localparam logic [2:0] StMul0 = 3'd2;
  localparam logic [2:0] StMul1 = 3'd3;
  localparam logic [2:0] StMul2 = 3'd4;
  localparam logic [2:0] StSum  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]  st_q, st_d;
  logic [63:0] lcg_q, lcg_d;
  logic        res_valid_q, res_valid_d;
  logic [31:0] res_value_q;
  logic        op_q, op_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] bound_q, bound_d;
  logic [63:0] opnd_q, opnd_d;
  logic [31:0] cand_q, cand_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] cross_q, cross_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] next_state;
  logic        res_free;
  logic        res_we;

  assign empty    = !res_valid_q;
  assign value_o  = res_value_q;
  assign res_free = !res_valid_q || pop;

  // Shared multiplier: low x low, high x low, low x high in StMul0, StMul1 and StMul2
  assign mul_a = (st_q == StMul1) ? opnd_q[63:32] : opnd_q[31:0];
  assign mul_b = (st_q == StMul2) ? PcgMulHi : PcgMulLo;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Final sum of the mod 2^64 product plus increment
  assign next_state = acc_q + {cross_q, 32'd0} + PcgInc;

  // Sequencer
  always_comb begin
    st_d      = st_q;
    lcg_d     = lcg_q;
    op_d      = op_q;
    mask_d    = mask_q;
    bound_d   = bound_q;
    opnd_d    = opnd_q;
    cand_d    = cand_q;
    acc_d     = acc_q;
    cross_d   = cross_q;
    cmd_pop_o = 1'b0;
    res_we    = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          mask_d    = cmd_i.data[63:32];
          bound_d   = cmd_i.data[31:0];
          opnd_d    = (cmd_i.op == OpDraw) ? lcg_q : cmd_i.data;
          cand_d    = pcg_output(lcg_q) & cmd_i.data[63:32];
          st_d      = StMul0;
        end
      end
      StTry: begin
        opnd_d = lcg_q;
        cand_d = pcg_output(lcg_q) & mask_q;
        st_d   = StMul0;
      end
      StMul0: begin
        acc_d = mul_p;
        st_d  = StMul1;
      end
      StMul1: begin
        cross_d = mul_p[31:0];
        st_d    = StMul2;
      end
      StMul2: begin
        cross_d = cross_q + mul_p[31:0];
        st_d    = StSum;
      end
      StSum: begin
        lcg_d = next_state;
        if (op_q == OpReseed) begin
          st_d = StIdle;
        end else if (cand_q > bound_q) begin
          st_d = StTry;
        end else if (res_free) begin
          res_we = 1'b1;
          st_d   = StIdle;
        end else begin
          st_d = StOut;
        end
      end
      StOut: begin
        if (res_free) begin
          res_we = 1'b1;
          st_d   = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  // Result slot occupancy
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_we) begin
      res_valid_d = 1'b1;
    end else if (pop) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      lcg_q       <= PcgResetState;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      lcg_q       <= lcg_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    mask_q  <= mask_d;
    bound_q <= bound_d;
    opnd_q  <= opnd_d;
    cand_q  <= cand_d;
    acc_q   <= acc_d;
    cross_q <= cross_d;
    if (res_we) begin
      res_value_q <= cand_q;
    end
  end

  // A result never exceeds its bound
  a_res_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> (cand_q <= bound_q))
    else $error("result above bound");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> (!res_valid_q || pop))
    else $error("result slot overwritten");

  // Commands are taken only when idle and present
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (st_q == StIdle && !cmd_empty_i))
    else $error("command popped out of idle");

  // Multiply sequence runs to the sum without gaps
  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StMul0) |=> (st_q == StMul1) ##1 (st_q == StMul2) ##1 (st_q == StSum))
    else $error("multiply sequence broken");

  // The LCG state changes only at the final sum
  a_state_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StSum) |=> $stable(lcg_q))
    else $error("state changed outside sum step");

endmodule

// ===== src/pcg32_bounded_random.sv =====
// Flow: the back end takes a command only in StIdle and steps through StMul0, StMul1,
// StMul2 and StSum; a reseed ends there, a passing draw is written to the result
// register (via StOut while it is full), a rejected draw reruns StTry and the multiply
// states. Each LCG step is three partial products on the shared 32x32 multiplier plus a
// sum; a 2-entry command queue and a result register decouple input and output.
// Reset: asynchronous, active low; state becomes that of a reseed with seed zero.
module pcg32_bounded_random import pcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [63:0] seed_i,
  input  logic [31:0] bound_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_o
);

  pcgr_cmd_t front_cmd;
  pcgr_cmd_t back_cmd;
  logic      cmd_empty;
  logic      cmd_pop;

  // Classify incoming beat
  pcgr_front u_front (
    .operation_i (operation_i),
    .seed_i      (seed_i),
    .bound_i     (bound_i),
    .cmd_o       (front_cmd)
  );

  // Command queue
  pcgr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  // Generator and rejection loop
  pcgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .value_o     (value_o)
  );

endmodule

// ===== tb/pcg32_bounded_random_tb.sv =====
// Self-checking testbench for the bounded PCG32 generator: queue-style push/pop traffic.
module pcg32_bounded_random_tb import pcgr_pkg::*; ();

  // Tracks the generator state and the draw values still owed by the block
  class pcg_draw_board;
    logic [63:0] lcg;
    logic [31:0] owed_values[$];
    int unsigned mismatches;

    function new();
      lcg = PcgResetState;
      mismatches = 0;
    endfunction

    // XSH-RR permutation of one state word
    function logic [31:0] permute(logic [63:0] s);
      logic [31:0] x;
      int unsigned r;
      x = 32'((s ^ (s >> XshShift)) >> OutShift);
      r = 32'(s[63:RotShift]);
      if (r == 0) return x;
      return (x >> r) | (x << (32 - r));
    endfunction

    // Bitmask rejection: keep drawing until the masked word fits under the bound
    function logic [31:0] bounded_draw(logic [31:0] bound);
      logic [31:0] mask;
      logic [31:0] v;
      logic [31:0] b1;
      int msb;
      b1 = bound | 32'd1;
      msb = 0;
      for (int i = 0; i < 32; i++) if (b1[i]) msb = i;
      mask = 32'((64'd1 << (msb + 1)) - 64'd1);
      do begin
        v = permute(lcg) & mask;
        lcg = lcg * PcgMul + PcgInc;
      end while (v > bound);
      return v;
    endfunction

    // Accepted input beat
    function void note_command(logic op, logic [63:0] seed, logic [31:0] bound);
      if (op == OpReseed) lcg = (PcgInc + seed) * PcgMul + PcgInc;
      else owed_values.push_back(bounded_draw(bound));
    endfunction

    // Accepted result beat
    function void check_value(logic [31:0] got);
      logic [31:0] want;
      if (owed_values.size() == 0) begin
        $error("value: no draw outstanding, actual %h", got);
        mismatches++;
        return;
      end
      want = owed_values.pop_front();
      if (got !== want) begin
        $error("value: expected %h, actual %h", want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_values.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push;
  logic        full;
  logic        operation_i;
  logic [63:0] seed_i;
  logic [31:0] bound_i;
  logic        empty;
  logic        pop;
  logic [31:0] value_o;

  pcg_draw_board board = new();
  bit            calm = 1'b0;

  pcg32_bounded_random i_dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .operation_i,
    .seed_i,
    .bound_i,
    .empty,
    .pop,
    .value_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long; none in a calm stretch
  function int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Bounds weighted toward the rejection corners
  function logic [31:0] pick_bound();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << k;
      3: return (32'd1 << k) - 32'd1;
      4: return $urandom_range(0, 15);
      default: return $urandom >> k;
    endcase
  endfunction

  task automatic send_item(logic op, logic [63:0] sd, logic [31:0] bd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    operation_i <= op;
    seed_i      <= sd;
    bound_i     <= bd;
    do @(posedge clk_i); while (full);
    board.note_command(op, sd, bd);
  endtask

  task automatic send_draw(logic [31:0] bd);
    send_item(OpDraw, {$urandom, $urandom}, bd);
  endtask

  task automatic send_reseed(logic [63:0] sd);
    send_item(OpReseed, sd, $urandom);
  endtask

  // Result side: random stalls, pop a beat whenever one is offered
  initial begin
    int stall;
    pop <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_value(value_o);
    end
  end

  // Stimulus
  initial begin
    push        <= 1'b0;
    operation_i <= OpReseed;
    seed_i      <= '0;
    bound_i     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bound extremes from the reset state, then reseed corners
    send_draw(32'hFFFF_FFFF);
    send_draw(32'd0);
    send_draw(32'd1);
    send_draw(32'd2);
    send_draw(32'h8000_0000);
    send_draw(32'h7FFF_FFFF);
    send_draw(32'h0001_0000);
    send_reseed(64'd0);
    send_draw(32'hFFFF_FFFF);
    send_draw(32'd0);
    send_reseed(64'hFFFF_FFFF_FFFF_FFFF);
    send_draw(32'hFFFF_FFFE);
    send_reseed(64'd1);
    send_reseed(64'h8000_0000_0000_0000);
    send_draw(32'h5555_5555);
    send_draw(32'hAAAA_AAAA);
    send_reseed(64'h0123_4567_89AB_CDEF);
    send_draw(32'd3);
    send_draw(32'hFFFF_FFFF);

    // Random: mostly draws, with reseeds mixed in; calm stretches now and then
    for (int n = 0; n < 1030; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 2) send_reseed({$urandom, $urandom});
      else send_draw(pick_bound());
    end
    push <= 1'b0;
    calm = 1'b1;

    // Drain, then watch for stray result beats
    for (int w = 0; w < 20000 && board.pending() != 0; w++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("value: %0d draws never returned", board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pcgr_pkg.sv
src/pcgr_front.sv
src/pcgr_cmd_fifo.sv
src/pcgr_back.sv
src/pcg32_bounded_random.sv
tb/pcg32_bounded_random_tb.sv
